@@ rtl/clns_pkg.sv @@
// Shared types, codes and constants for the character-LCD nibble sequencer.
// Used by the front end, the job queue, the phase engine and the top level.
`timescale 1ns / 1ps

package clns_pkg;

   // request function codes
   localparam logic [2:0] FUNC_TEXT   = 3'd0;
   localparam logic [2:0] FUNC_CMD    = 3'd1;
   localparam logic [2:0] FUNC_CLEAR  = 3'd2;
   localparam logic [2:0] FUNC_INIT   = 3'd3;
   localparam logic [2:0] FUNC_CURSOR = 3'd4;

   // configuration register indexes
   localparam int         CSR_IDX_W   = 2;
   localparam logic [1:0] CSR_SETUP   = 2'd0;
   localparam logic [1:0] CSR_PULSE   = 2'd1;
   localparam logic [1:0] CSR_SETTLE  = 2'd2;

   localparam logic [15:0] SETUP_RESET  = 16'(60 * 2);
   localparam logic [15:0] PULSE_RESET  = 16'(450 * 2);
   localparam logic [15:0] SETTLE_RESET = 16'(1200 * 2);

   localparam int HOLD_W = 26;
   localparam logic [HOLD_W-1:0] CLEAR_WAIT_NS = HOLD_W'(164 * 2 * 10 * 1000);
   localparam logic [HOLD_W-1:0] INIT_WAIT0_NS = HOLD_W'(40 * 1000 * 1000);
   localparam logic [HOLD_W-1:0] INIT_WAIT1_NS = HOLD_W'(8 * 1000 * 1000);
   localparam logic [HOLD_W-1:0] INIT_WAIT2_NS = HOLD_W'(200 * 1000);

   // wait selectors inside the power-up program
   localparam logic [1:0] WAIT_INIT0 = 2'd0;
   localparam logic [1:0] WAIT_INIT1 = 2'd1;
   localparam logic [1:0] WAIT_INIT2 = 2'd2;
   localparam logic [1:0] WAIT_CLEAR = 2'd3;

   localparam logic [7:0] CMD_SET_ADDR = 8'b1000_0000;
   localparam logic [7:0] LINE1_OFFSET = 8'h40;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // program steps: power-up runs the whole table, clear runs steps 11..13 of it
   localparam logic [3:0] INIT_FIRST_OP  = 4'd0;
   localparam logic [3:0] INIT_LAST_OP   = 4'd15;
   localparam logic [3:0] CLEAR_FIRST_OP = 4'd11;
   localparam logic [3:0] CLEAR_LAST_OP  = 4'd13;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [15:0] setup_ns;
      logic [15:0] pulse_ns;
      logic [15:0] settle_ns;
   } cfg_type;

   // one job for the phase engine
   typedef struct packed {
      logic       tbl;       // run the fixed program instead of a byte
      logic       rs;
      logic [7:0] data;
      logic [3:0] first_op;
      logic [3:0] last_op;
   } job_type;

   typedef struct packed {
      logic       is_wait;
      logic [1:0] wait_sel;
      logic [3:0] nib;
   } op_type;

   function automatic op_type nib_op(input logic [3:0] nib);
      op_type o;
      o.is_wait  = 1'b0;
      o.wait_sel = WAIT_INIT0;
      o.nib      = nib;
      return o;
   endfunction

   function automatic op_type wait_op(input logic [1:0] sel);
      op_type o;
      o.is_wait  = 1'b1;
      o.wait_sel = sel;
      o.nib      = 4'h0;
      return o;
   endfunction

   // power-up program; the clear command plus its wait sits at steps 11..13
   function automatic op_type prog_op(input logic [3:0] idx);
      op_type o;
      case (idx)
         4'd0:    o = wait_op(WAIT_INIT0);
         4'd1:    o = nib_op(4'h3);
         4'd2:    o = wait_op(WAIT_INIT1);
         4'd3:    o = nib_op(4'h3);
         4'd4:    o = wait_op(WAIT_INIT2);
         4'd5:    o = nib_op(4'h3);
         4'd6:    o = nib_op(4'h2);
         4'd7:    o = nib_op(4'h2);
         4'd8:    o = nib_op(4'h8);
         4'd9:    o = nib_op(4'h0);
         4'd10:   o = nib_op(4'hC);
         4'd11:   o = nib_op(4'h0);
         4'd12:   o = nib_op(4'h1);
         4'd13:   o = wait_op(WAIT_CLEAR);
         4'd14:   o = nib_op(4'h0);
         default: o = nib_op(4'h6);
      endcase
      return o;
   endfunction

   function automatic logic [HOLD_W-1:0] wait_hold(input logic [1:0] sel);
      logic [HOLD_W-1:0] h;
      case (sel)
         WAIT_INIT0: h = INIT_WAIT0_NS;
         WAIT_INIT1: h = INIT_WAIT1_NS;
         WAIT_INIT2: h = INIT_WAIT2_NS;
         default:    h = CLEAR_WAIT_NS;
      endcase
      return h;
   endfunction

endpackage

@@ rtl/clns_front.sv @@
// Front end: accepts requests, tracks the text line and turns each request
// into a job for the queue. Depends on clns_pkg.
`timescale 1ns / 1ps

module clns_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_func,
   input  logic [7:0]           req_byte_req,
   input  logic [1:0]           req_line,
   input  logic [5:0]           req_column,
   input  logic                 req_text_start,
   input  logic                 q_full,
   output logic                 q_push,
   output clns_pkg::job_type    q_job
);
   import clns_pkg::*;

   logic [1:0] line_ff, line_in;
   logic [1:0] line_base;
   logic       accept;
   logic       emit;
   job_type    job;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign line_base = req_text_start ? 2'd0 : line_ff;

   always_comb begin
      job          = '0;
      job.first_op = 4'd0;
      job.last_op  = 4'd1;
      emit         = 1'b0;
      line_in      = line_ff;
      case (req_func)
         FUNC_TEXT: begin
            line_in = line_base;
            if (req_byte_req == CHAR_NEWLINE) begin
               line_in = (line_base == 2'd2) ? 2'd2 : line_base + 2'd1;
               // move to the second line only when it is reached
               emit     = (line_in == 2'd1);
               job.data = CMD_SET_ADDR | LINE1_OFFSET;
            end else if (req_byte_req != 8'h00) begin
               emit     = 1'b1;
               job.rs   = 1'b1;
               job.data = req_byte_req;
            end
         end
         FUNC_CMD: begin
            emit     = 1'b1;
            job.data = req_byte_req;
         end
         FUNC_CLEAR: begin
            emit         = 1'b1;
            job.tbl      = 1'b1;
            job.first_op = CLEAR_FIRST_OP;
            job.last_op  = CLEAR_LAST_OP;
         end
         FUNC_INIT: begin
            emit         = 1'b1;
            job.tbl      = 1'b1;
            job.first_op = INIT_FIRST_OP;
            job.last_op  = INIT_LAST_OP;
         end
         FUNC_CURSOR: begin
            if (req_line == 2'd0) begin
               emit     = 1'b1;
               job.data = {2'b10, req_column};
            end else if (req_line == 2'd1) begin
               emit     = 1'b1;
               job.data = {2'b11, req_column};
            end
         end
         default: emit = 1'b0;
      endcase
   end

   assign q_push = accept && emit;
   assign q_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= 2'd0;
      end else if (accept) begin
         line_ff <= line_in;
      end
   end

endmodule

@@ rtl/clns_queue.sv @@
// Short job queue between the front end and the phase engine.
// Depends on clns_pkg for the job type.
`timescale 1ns / 1ps

module clns_queue #(
   parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  clns_pkg::job_type    push_job,
   output logic                 full,
   input  logic                 pop,
   output clns_pkg::job_type    pop_job,
   output logic                 empty
);
   import clns_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slots_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/clns_back.sv @@
// Phase engine: steps through a job's nibbles and waits, one pin phase per
// cycle while rsp_stall allows, into the result register. Depends on clns_pkg.
`timescale 1ns / 1ps

module clns_back (
   input  logic                          clock,
   input  logic                          reset,
   input  clns_pkg::cfg_type             cfg,
   input  logic                          q_empty,
   input  clns_pkg::job_type             q_job,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_rs_level,
   output logic                          rsp_enable,
   output logic [3:0]                    rsp_nibble,
   output logic [clns_pkg::HOLD_W-1:0]   rsp_hold_ns,
   output logic                          rsp_last
);
   import clns_pkg::*;

   logic              busy_ff, busy_in;
   job_type           job_ff, job_in;
   logic [3:0]        op_idx_ff, op_idx_in;
   logic [1:0]        phase_ff, phase_in;
   logic              rs_held_ff, rs_held_in;
   logic [3:0]        data_held_ff, data_held_in;

   logic              valid_ff, valid_in;
   logic              rs_ff, rs_in;
   logic              en_ff, en_in;
   logic [3:0]        nib_ff, nib_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic              last_ff, last_in;

   op_type            op;
   logic              op_rs;
   logic              out_free, advance, op_done, job_done;

   assign out_free = !valid_ff || !rsp_stall;
   assign advance  = busy_ff && out_free;

   always_comb begin
      if (job_ff.tbl) begin
         op    = prog_op(op_idx_ff);
         op_rs = 1'b0;
      end else begin
         op    = nib_op(op_idx_ff[0] ? job_ff.data[3:0] : job_ff.data[7:4]);
         op_rs = job_ff.rs;
      end
   end

   assign op_done  = op.is_wait || (phase_ff == 2'd2);
   assign job_done = op_done && (op_idx_ff == job_ff.last_op);
   assign q_pop    = !q_empty && (!busy_ff || (advance && job_done));

   // phase pins
   always_comb begin
      rs_held_in   = rs_held_ff;
      data_held_in = data_held_ff;
      rs_in        = rs_held_ff;
      en_in        = 1'b0;
      nib_in       = data_held_ff;
      hold_in      = wait_hold(op.wait_sel);
      if (!op.is_wait) begin
         case (phase_ff)
            2'd0: begin
               rs_in      = op_rs;
               rs_held_in = op_rs;
               hold_in    = HOLD_W'(cfg.setup_ns);
            end
            2'd1: begin
               en_in        = 1'b1;
               nib_in       = op.nib;
               data_held_in = op.nib;
               hold_in      = HOLD_W'(cfg.pulse_ns);
            end
            default: begin
               nib_in  = op.nib;
               hold_in = HOLD_W'(cfg.settle_ns);
            end
         endcase
      end
      last_in  = job_done;
      valid_in = out_free ? busy_ff : valid_ff;
   end

   // job sequencing
   always_comb begin
      busy_in   = busy_ff;
      job_in    = job_ff;
      op_idx_in = op_idx_ff;
      phase_in  = phase_ff;
      if (q_pop) begin
         busy_in   = 1'b1;
         job_in    = q_job;
         op_idx_in = q_job.first_op;
         phase_in  = 2'd0;
      end else if (advance) begin
         if (job_done) begin
            busy_in = 1'b0;
         end else if (op_done) begin
            op_idx_in = op_idx_ff + 4'd1;
            phase_in  = 2'd0;
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         valid_ff     <= 1'b0;
         rs_held_ff   <= 1'b0;
         data_held_ff <= 4'h0;
         op_idx_ff    <= 4'd0;
         phase_ff     <= 2'd0;
      end else begin
         busy_ff   <= busy_in;
         valid_ff  <= valid_in;
         op_idx_ff <= op_idx_in;
         phase_ff  <= phase_in;
         if (advance) begin
            rs_held_ff   <= rs_held_in;
            data_held_ff <= data_held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (advance) begin
         rs_ff   <= rs_in;
         en_ff   <= en_in;
         nib_ff  <= nib_in;
         hold_ff <= hold_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_rs_level = rs_ff;
   assign rsp_enable   = en_ff;
   assign rsp_nibble   = nib_ff;
   assign rsp_hold_ns  = hold_ff;
   assign rsp_last     = last_ff;

endmodule

@@ rtl/char_lcd_nibble_sequencer_unit.sv @@
// Top level of the character-LCD nibble sequencer: timing registers plus the
// front end, job queue and phase engine. Depends on clns_pkg.
//
//   channel  | direction | handshake           | beat
//   req_     | in        | req_valid/req_stall | one request
//   rsp_     | out       | rsp_valid/rsp_stall | one pin phase
//   csr_     | in        | csr_valid/csr_ready | one register write
//
// A byte gives six pin phases, clear seven, power-up forty, one phase per cycle
// while rsp_stall is low; the phase engine sets the rate and jobs run back to
// back from the queue. Requests that emit nothing do not enter the queue.
// Reset is synchronous; timing registers return to 120/900/2400 ns.
// req_stall rises only when the job queue is full; rsp_stall holds the phase.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_unit #(
   parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_func,
   input  logic [7:0]                         req_byte_req,
   input  logic [1:0]                         req_line,
   input  logic [5:0]                         req_column,
   input  logic                               req_text_start,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_rs_level,
   output logic                               rsp_enable,
   output logic [3:0]                         rsp_nibble,
   output logic [clns_pkg::HOLD_W-1:0]        rsp_hold_ns,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [clns_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                        csr_data
);
   import clns_pkg::*;

   cfg_type cfg_ff;
   logic    q_push, q_full, q_pop, q_empty;
   job_type push_job, pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_ns  <= SETUP_RESET;
         cfg_ff.pulse_ns  <= PULSE_RESET;
         cfg_ff.settle_ns <= SETTLE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SETUP:  cfg_ff.setup_ns  <= csr_data;
            CSR_PULSE:  cfg_ff.pulse_ns  <= csr_data;
            CSR_SETTLE: cfg_ff.settle_ns <= csr_data;
            default:    cfg_ff <= cfg_ff;
         endcase
      end
   end

   clns_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_byte_req   (req_byte_req),
      .req_line       (req_line),
      .req_column     (req_column),
      .req_text_start (req_text_start),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   clns_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   clns_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_empty      (q_empty),
      .q_job        (pop_job),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_rs_level (rsp_rs_level),
      .rsp_enable   (rsp_enable),
      .rsp_nibble   (rsp_nibble),
      .rsp_hold_ns  (rsp_hold_ns),
      .rsp_last     (rsp_last)
   );

endmodule

@@ sim/char_lcd_nibble_sequencer_unit_tb.sv @@
// Self-checking bench for char_lcd_nibble_sequencer_unit: directed requests, then random ones,
// checked phase by phase against a predictor of the LCD pin sequence.
// Depends on clns_pkg and the RTL top level only.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_unit_tb;
   import clns_pkg::*;

   localparam int HALF_PERIOD      = 5;
   localparam int TIMEOUT_NS       = 5_000_000;
   localparam int DRAIN_LIMIT      = 20000;
   localparam int TAIL_CYCLES      = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PER_PASS  = 27;
   localparam int LISTED_NONE      = -1;

   localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;
   localparam logic [1:0] CSR_SPARE         = 2'd3;

   localparam logic [7:0] LCD_CMD_CLEAR      = 8'b0000_0001;
   localparam logic [7:0] LCD_CMD_FUNC_SET   = 8'b0010_1000;
   localparam logic [7:0] LCD_CMD_DISPLAY_ON = 8'b0000_1100;
   localparam logic [7:0] LCD_CMD_ENTRY_MODE = 8'b0000_0110;
   localparam logic [3:0] LCD_NIB_WAKE       = 4'h3;
   localparam logic [3:0] LCD_NIB_4BIT       = 4'h2;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] byte_req;
      logic [1:0] line;
      logic [5:0] column;
      logic       text_start;
   } request_type;

   typedef struct packed {
      logic              rs_level;
      logic              enable;
      logic [3:0]        nibble;
      logic [HOLD_W-1:0] hold_ns;
      logic              last;
   } pin_phase_type;

   typedef struct {
      request_type req;
      int          phases;
   } lcd_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [2:0]           req_func;
   logic [7:0]           req_byte_req;
   logic [1:0]           req_line;
   logic [5:0]           req_column;
   logic                 req_text_start;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_rs_level;
   logic                 rsp_enable;
   logic [3:0]           rsp_nibble;
   logic [HOLD_W-1:0]    rsp_hold_ns;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_data;

   // predictor copy of the timing registers and pin state
   logic [15:0] t_setup;
   logic [15:0] t_pulse;
   logic [15:0] t_settle;
   logic [1:0]  line_no;
   logic        pin_rs;
   logic [3:0]  pin_data;

   pin_phase_type expected_phases[$];
   pin_phase_type burst[$];
   int            listed_phase_counts[$];

   int  mismatch_count = 0;
   int  requests_seen  = 0;
   int  phases_checked = 0;
   int  csr_writes     = 0;
   int  send_idle_pct  = 0;
   int  recv_idle_pct  = 0;
   logic long_hold = 1'b0;
   event hold_off_go;

   lcd_row_type directed_rows[22] = '{
      '{'{FUNC_CMD,    8'h00, 2'd0, 6'd0,  1'b0}, 6},   // reset timing
      '{'{FUNC_CMD,    8'hFF, 2'd3, 6'd63, 1'b1}, 6},   // start flag ignored
      '{'{FUNC_TEXT,   8'h41, 2'd0, 6'd0,  1'b1}, 6},
      '{'{FUNC_TEXT,   8'hFF, 2'd3, 6'd63, 1'b0}, 6},
      '{'{FUNC_TEXT,   8'h00, 2'd0, 6'd0,  1'b0}, 0},   // end of text
      '{'{FUNC_TEXT,   8'h0A, 2'd0, 6'd0,  1'b0}, 6},   // newline to line one
      '{'{FUNC_TEXT,   8'h0A, 2'd0, 6'd0,  1'b0}, 0},   // line two is silent
      '{'{FUNC_TEXT,   8'h0A, 2'd0, 6'd0,  1'b0}, 0},   // saturated
      '{'{FUNC_TEXT,   8'h0A, 2'd0, 6'd0,  1'b1}, 6},
      '{'{FUNC_TEXT,   8'h00, 2'd0, 6'd0,  1'b1}, 0},   // line reset, no output
      '{'{FUNC_TEXT,   8'h0A, 2'd0, 6'd0,  1'b0}, 6},
      '{'{FUNC_CLEAR,  8'h5A, 2'd1, 6'd5,  1'b1}, 7},
      '{'{FUNC_INIT,   8'h00, 2'd0, 6'd0,  1'b0}, 40},
      '{'{FUNC_CURSOR, 8'h00, 2'd0, 6'd0,  1'b0}, 6},
      '{'{FUNC_CURSOR, 8'hFF, 2'd1, 6'd39, 1'b0}, 6},
      '{'{FUNC_CURSOR, 8'h00, 2'd0, 6'd63, 1'b0}, 6},   // column past the display
      '{'{FUNC_CURSOR, 8'h00, 2'd1, 6'd63, 1'b1}, 6},
      '{'{FUNC_CURSOR, 8'h00, 2'd2, 6'd5,  1'b0}, 0},
      '{'{FUNC_CURSOR, 8'h00, 2'd3, 6'd63, 1'b0}, 0},
      '{'{FUNC_UNUSED_FIRST, 8'hFF, 2'd3, 6'd63, 1'b1}, 0},
      '{'{FUNC_UNUSED_LAST,  8'h0A, 2'd1, 6'd1,  1'b0}, 0},
      '{'{FUNC_CMD,    8'hA5, 2'd0, 6'd0,  1'b0}, 6}
   };

   char_lcd_nibble_sequencer_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_byte_req   (req_byte_req),
      .req_line       (req_line),
      .req_column     (req_column),
      .req_text_start (req_text_start),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rs_level   (rsp_rs_level),
      .rsp_enable     (rsp_enable),
      .rsp_nibble     (rsp_nibble),
      .rsp_hold_ns    (rsp_hold_ns),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // --- pin sequence predictor ---
   task automatic put_phase(input logic rs, input logic en, input logic [3:0] nib,
                            input logic [HOLD_W-1:0] hold);
      pin_phase_type p;
      p.rs_level = rs;
      p.enable   = en;
      p.nibble   = nib;
      p.hold_ns  = hold;
      p.last     = 1'b0;
      burst.push_back(p);
   endtask

   task automatic put_wait(input logic [HOLD_W-1:0] hold);
      put_phase(pin_rs, 1'b0, pin_data, hold);
   endtask

   task automatic put_nibble(input logic rs, input logic [3:0] nib);
      pin_rs = rs;
      put_phase(pin_rs, 1'b0, pin_data, HOLD_W'(t_setup));
      pin_data = nib;
      put_phase(pin_rs, 1'b1, pin_data, HOLD_W'(t_pulse));
      put_phase(pin_rs, 1'b0, pin_data, HOLD_W'(t_settle));
   endtask

   task automatic put_byte(input logic rs, input logic [7:0] b);
      put_nibble(rs, b[7:4]);
      put_nibble(rs, b[3:0]);
   endtask

   task automatic put_clear();
      put_byte(1'b0, LCD_CMD_CLEAR);
      put_wait(CLEAR_WAIT_NS);
   endtask

   task automatic predict_pin_phases(input request_type r, output int count);
      pin_phase_type p;
      burst.delete();
      case (r.func)
         FUNC_TEXT: begin
            if (r.text_start)
               line_no = 2'd0;
            if (r.byte_req == CHAR_NEWLINE) begin
               if (line_no < 2'd2)
                  line_no = line_no + 2'd1;
               if (line_no == 2'd1)
                  put_byte(1'b0, CMD_SET_ADDR | LINE1_OFFSET);
            end else if (r.byte_req != 8'h00) begin
               put_byte(1'b1, r.byte_req);
            end
         end
         FUNC_CMD:   put_byte(1'b0, r.byte_req);
         FUNC_CLEAR: put_clear();
         FUNC_INIT: begin
            put_wait(INIT_WAIT0_NS);
            put_nibble(1'b0, LCD_NIB_WAKE);
            put_wait(INIT_WAIT1_NS);
            put_nibble(1'b0, LCD_NIB_WAKE);
            put_wait(INIT_WAIT2_NS);
            put_nibble(1'b0, LCD_NIB_WAKE);
            put_nibble(1'b0, LCD_NIB_4BIT);
            put_byte(1'b0, LCD_CMD_FUNC_SET);
            put_byte(1'b0, LCD_CMD_DISPLAY_ON);
            put_clear();
            put_byte(1'b0, LCD_CMD_ENTRY_MODE);
         end
         FUNC_CURSOR: begin
            if (r.line == 2'd0)
               put_byte(1'b0, CMD_SET_ADDR | {2'b00, r.column});
            else if (r.line == 2'd1)
               put_byte(1'b0, CMD_SET_ADDR | LINE1_OFFSET | {2'b00, r.column});
         end
         default: ;
      endcase
      count = burst.size();
      if (count > 0) begin
         p = burst.pop_back();
         p.last = 1'b1;
         burst.push_back(p);
      end
      foreach (burst[i])
         expected_phases.push_back(burst[i]);
   endtask

   task automatic check_pin_phase(input pin_phase_type got);
      pin_phase_type want;
      if (expected_phases.size() == 0) begin
         report_mismatch("pin phase with nothing expected");
      end else begin
         want = expected_phases.pop_front();
         if (got.rs_level != want.rs_level)
            report_mismatch($sformatf("rs_level %0b, want %0b", got.rs_level, want.rs_level));
         if (got.enable != want.enable)
            report_mismatch($sformatf("enable %0b, want %0b", got.enable, want.enable));
         if (got.nibble != want.nibble)
            report_mismatch($sformatf("nibble %h, want %h", got.nibble, want.nibble));
         if (got.hold_ns != want.hold_ns)
            report_mismatch($sformatf("hold_ns %0d, want %0d", got.hold_ns, want.hold_ns));
         if (got.last != want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      end
      phases_checked++;
   endtask

   // sample every handshake at the rising edge; predict before checking
   always @(posedge clock) begin
      request_type   seen;
      pin_phase_type got;
      int            made;
      int            listed;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SETUP:  t_setup  = csr_data;
               CSR_PULSE:  t_pulse  = csr_data;
               CSR_SETTLE: t_settle = csr_data;
               default: ;
            endcase
            csr_writes++;
         end
         if (req_valid && !req_stall) begin
            seen = '{req_func, req_byte_req, req_line, req_column, req_text_start};
            predict_pin_phases(seen, made);
            listed = (listed_phase_counts.size() != 0) ? listed_phase_counts.pop_front()
                                                       : LISTED_NONE;
            if (listed != LISTED_NONE && listed != made)
               report_mismatch($sformatf("request %0d listed for %0d phases, predicted %0d",
                                         requests_seen, listed, made));
            requests_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_rs_level, rsp_enable, rsp_nibble, rsp_hold_ns, rsp_last};
            check_pin_phase(got);
         end
      end
   end

   // output side: random stall, or hold off completely while long_hold is up
   always @(negedge clock) begin
      if (long_hold)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   initial begin
      forever begin
         @(hold_off_go);
         long_hold = 1'b1;
         repeat (LONG_HOLD_CYCLES) @(posedge clock);
         long_hold = 1'b0;
      end
   end

   task automatic drive_request(input request_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= r.func;
      req_byte_req   <= r.byte_req;
      req_line       <= r.line;
      req_column     <= r.column;
      req_text_start <= r.text_start;
      // hold the beat until it is taken
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_timing(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      int waited;
      waited = 0;
      while (expected_phases.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // let silent requests finish before touching the registers
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_phases.size() != 0) begin
         report_mismatch($sformatf("%0d pin phases never arrived", expected_phases.size()));
         expected_phases.delete();
      end
   endtask

   // mostly well-formed text and commands, with a few ignored codes mixed in
   task automatic send_random_requests(input int wanted);
      request_type r;
      int          active;
      int          pick;
      int          k;
      active = 0;
      while (active < wanted) begin
         pick         = $urandom_range(99);
         r.byte_req   = 8'($urandom_range(255));
         r.line       = 2'($urandom_range(3));
         r.column     = 6'($urandom_range(63));
         r.text_start = ($urandom_range(3) == 0);
         if (pick < 45) begin
            r.func = FUNC_TEXT;
            k = $urandom_range(19);
            if (k < 3)
               r.byte_req = CHAR_NEWLINE;
            else if (k == 3)
               r.byte_req = 8'h00;
         end else if (pick < 65) begin
            r.func = FUNC_CMD;
         end else if (pick < 78) begin
            r.func = FUNC_CURSOR;
         end else if (pick < 85) begin
            r.func = FUNC_CLEAR;
         end else if (pick < 88) begin
            r.func = FUNC_INIT;
         end else begin
            r.func = 3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
         end
         listed_phase_counts.push_back(LISTED_NONE);
         drive_request(r);
         if (r.func <= FUNC_CURSOR && !(r.func == FUNC_CURSOR && r.line > 2'd1))
            active++;
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   initial begin
      t_setup        = SETUP_RESET;
      t_pulse        = PULSE_RESET;
      t_settle       = SETTLE_RESET;
      line_no        = 2'd0;
      pin_rs         = 1'b0;
      pin_data       = 4'h0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_func       <= FUNC_TEXT;
      req_byte_req   <= 8'h00;
      req_line       <= 2'd0;
      req_column     <= 6'd0;
      req_text_start <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_SETUP;
      csr_data       <= 16'h0000;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table with reset timing
      send_idle_pct = 11;
      recv_idle_pct = 52;
      foreach (directed_rows[i]) begin
         listed_phase_counts.push_back(directed_rows[i].phases);
         drive_request(directed_rows[i].req);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();

      write_timing(CSR_SETUP, 16'h0000);
      write_timing(CSR_PULSE, 16'hFFFF);
      write_timing(CSR_SETTLE, 16'h0001);
      write_timing(CSR_SPARE, 16'hFFFF);
      send_random_requests(RANDOM_PER_PASS);
      wait_for_drain();

      send_idle_pct = 52;
      recv_idle_pct = 11;
      write_timing(CSR_SETUP, 16'hFFFF);
      write_timing(CSR_PULSE, 16'h0000);
      write_timing(CSR_SETTLE, 16'hFFFF);
      send_random_requests(RANDOM_PER_PASS);
      wait_for_drain();

      // no idling; hold the output off so the job queue fills
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_timing(CSR_SETUP, 16'($urandom_range(65535)));
      write_timing(CSR_PULSE, 16'($urandom_range(65535)));
      write_timing(CSR_SETTLE, 16'($urandom_range(65535)));
      -> hold_off_go;
      send_random_requests(RANDOM_PER_PASS);
      wait_for_drain();

      $display("%0d requests, %0d pin phases compared, %0d timing writes",
               requests_seen, phases_checked, csr_writes);
      $display("timing at both extremes and random, idling on each side, long output hold-off");
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TIMEOUT at %0t ns", $time);
      $display("simulation failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/clns_pkg.sv
rtl/clns_front.sv
rtl/clns_queue.sv
rtl/clns_back.sv
rtl/char_lcd_nibble_sequencer_unit.sv
sim/char_lcd_nibble_sequencer_unit_tb.sv
